// ----- hdl/fdtd_pkg.sv -----
package fdtd_pkg;

	localparam int GRID_CELLS = 1024;
	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int CELL_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int ACC_W      = 64;
	localparam int IDX_W      = $clog2(GRID_CELLS);
	localparam int LEN_W      = ((IDX_W > CELL_W) ? IDX_W : CELL_W) + 1;

	localparam logic signed [DATA_W-1:0] UNITY = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_READ    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_H_COEF        = 2'd0,
		CFG_E_COEF        = 2'd1,
		CFG_SOURCE_GAIN   = 2'd2,
		CFG_ACTIVE_LENGTH = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_READ_ADDR,
		ST_READ_DATA,
		ST_RD_LO,
		ST_RD_HI,
		ST_RD_MID,
		ST_MUL1,
		ST_SUM,
		ST_MUL2,
		ST_WB,
		ST_SRC_MUL,
		ST_SRC_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic cap_lo;
		logic calc_diff;
		logic mul1;
		logic sum;
		logic mul2;
		logic wb;
		logic src_mul;
		logic src_wb;
	} alu_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     ovf;
	} clamp_t;

	localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] MIN_V = -MAX_V - ACC_W'(1);

	function automatic clamp_t clamp(input logic signed [ACC_W-1:0] v);
		clamp_t r;
		if (v > MAX_V) begin
			r.val = MAX_V[DATA_W-1:0];
			r.ovf = 1'b1;
		end else if (v < MIN_V) begin
			r.val = MIN_V[DATA_W-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = v[DATA_W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] fl(input logic signed [ACC_W-1:0] p);
		return p >>> FRAC_BITS;
	endfunction

endpackage

// ----- hdl/fdtd_item_if.sv -----
interface fdtd_item_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             action;
	logic [fdtd_pkg::CELL_W-1:0]            cell_index;
	logic signed [fdtd_pkg::DATA_W-1:0]     decay_value;
	logic signed [fdtd_pkg::DATA_W-1:0]     couple_value;
	logic signed [fdtd_pkg::DATA_W-1:0]     stretch_value;
	logic signed [fdtd_pkg::DATA_W-1:0]     source_value;

	modport source(output valid, action, cell_index, decay_value, couple_value,
		stretch_value, source_value, input ready);
	modport sink(input valid, action, cell_index, decay_value, couple_value,
		stretch_value, source_value, output ready);
endinterface

// ----- hdl/fdtd_result_if.sv -----
interface fdtd_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [fdtd_pkg::DATA_W-1:0] field_value;
	logic [fdtd_pkg::DATA_W-1:0]        step_number;
	logic                               saturated;

	modport source(output valid, field_value, step_number, saturated, input ready);
	modport sink(input valid, field_value, step_number, saturated, output ready);
endinterface

// ----- hdl/fdtd_cfg_if.sv -----
interface fdtd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [fdtd_pkg::CFG_IDX_W-1:0]     index;
	logic [fdtd_pkg::DATA_W-1:0]        data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/fdtd_1d_cpml_plane_wave_unit.sv -----
// load: LOAD, DONE; read: READ_ADDR, READ_DATA, DONE; unused action: DONE; each then via the
// output register; advance: RD_LO, RD_HI, RD_MID, MUL1, SUM, MUL2, WB per updated cell,
// then SRC_MUL, SRC_WB, DONE, set by the single read port of the field memory and the two
// chained multiplies per cell; one item at a time; the next item is taken while the previous
// result waits; after reset a clearing pass over all GRID_CELLS (1024) addresses initializes
// all memories, no item is taken during it; configuration writes are taken at all times
module fdtd_1d_cpml_plane_wave_unit (
	input logic         clk,
	input logic         arst_n,
	fdtd_item_if.sink   item,
	fdtd_result_if.source result,
	fdtd_cfg_if.sink    cfg
);
	localparam int IW = fdtd_pkg::IDX_W;
	localparam int DW = fdtd_pkg::DATA_W;

	fdtd_pkg::state_t state_q, state_d;
	logic [IW-1:0]  cur_q, clr_q, last, fld_raddr, fld_waddr;
	logic [IW:0]    nxt;
	logic           odd_q, sat_q, rsat_q, more, more_even, in_range;
	logic [DW-1:0]  step_q;
	logic signed [DW-1:0] h_coef_q, e_coef_q, gain_q, rfv_q;
	logic [fdtd_pkg::CELL_W-1:0] al_q, idx_q;
	logic signed [DW-1:0] b_q, c_q, s_q, src_q;
	logic           out_valid_q, out_sat_q, done_fire;
	logic signed [DW-1:0] out_fv_q;
	logic [DW-1:0]  out_step_q;

	logic           fld_we, aux_we, coef_we;
	logic signed [DW-1:0] fld_wdata, aux_wdata, b_wdata, c_wdata, s_wdata;
	logic signed [DW-1:0] fld_rd, aux_rd, b_rd, c_rd, s_rd, aux_new, field_new, src_field;
	logic           ovf;
	fdtd_pkg::alu_ctl_t ctl;

	always_comb begin
		if (fdtd_pkg::LEN_W'(al_q) > fdtd_pkg::LEN_W'(fdtd_pkg::GRID_CELLS - 1)) begin
			last = IW'(fdtd_pkg::GRID_CELLS - 1);
		end else begin
			last = IW'(al_q);
		end
		nxt       = {1'b0, cur_q} + (IW+1)'(2);
		more      = nxt < {1'b0, last};
		more_even = odd_q && ((IW+1)'(2) < {1'b0, last});
		in_range  = 32'(idx_q) < 32'(fdtd_pkg::GRID_CELLS);
		done_fire = (state_q == fdtd_pkg::ST_DONE) && (!out_valid_q || result.ready);
	end

	assign item.ready = (state_q == fdtd_pkg::ST_IDLE);
	assign cfg.ready  = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fdtd_pkg::ST_CLEAR: begin
				if (clr_q == IW'(fdtd_pkg::GRID_CELLS - 1)) state_d = fdtd_pkg::ST_IDLE;
			end
			fdtd_pkg::ST_IDLE: begin
				if (item.valid) begin
					unique case (fdtd_pkg::action_t'(item.action))
						fdtd_pkg::ACT_LOAD:    state_d = fdtd_pkg::ST_LOAD;
						fdtd_pkg::ACT_ADVANCE: state_d = ((IW+1)'(1) < {1'b0, last}) ?
							fdtd_pkg::ST_RD_LO : fdtd_pkg::ST_SRC_MUL;
						fdtd_pkg::ACT_READ:    state_d = fdtd_pkg::ST_READ_ADDR;
						fdtd_pkg::ACT_NONE:    state_d = fdtd_pkg::ST_DONE;
						default:               state_d = fdtd_pkg::ST_DONE;
					endcase
				end
			end
			fdtd_pkg::ST_LOAD:      state_d = fdtd_pkg::ST_DONE;
			fdtd_pkg::ST_READ_ADDR: state_d = fdtd_pkg::ST_READ_DATA;
			fdtd_pkg::ST_READ_DATA: state_d = fdtd_pkg::ST_DONE;
			fdtd_pkg::ST_RD_LO:     state_d = fdtd_pkg::ST_RD_HI;
			fdtd_pkg::ST_RD_HI:     state_d = fdtd_pkg::ST_RD_MID;
			fdtd_pkg::ST_RD_MID:    state_d = fdtd_pkg::ST_MUL1;
			fdtd_pkg::ST_MUL1:      state_d = fdtd_pkg::ST_SUM;
			fdtd_pkg::ST_SUM:       state_d = fdtd_pkg::ST_MUL2;
			fdtd_pkg::ST_MUL2:      state_d = fdtd_pkg::ST_WB;
			fdtd_pkg::ST_WB: begin
				state_d = (more || more_even) ? fdtd_pkg::ST_RD_LO : fdtd_pkg::ST_SRC_MUL;
			end
			fdtd_pkg::ST_SRC_MUL:   state_d = fdtd_pkg::ST_SRC_WB;
			fdtd_pkg::ST_SRC_WB:    state_d = fdtd_pkg::ST_DONE;
			fdtd_pkg::ST_DONE: begin
				if (done_fire) state_d = fdtd_pkg::ST_IDLE;
			end
			default: state_d = fdtd_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl       = '0;
		fld_we    = 1'b0;
		aux_we    = 1'b0;
		coef_we   = 1'b0;
		fld_raddr = cur_q;
		fld_waddr = cur_q;
		fld_wdata = field_new;
		aux_wdata = aux_new;
		b_wdata   = b_q;
		c_wdata   = c_q;
		s_wdata   = s_q;
		unique case (state_q)
			fdtd_pkg::ST_CLEAR: begin
				fld_we    = 1'b1;
				aux_we    = 1'b1;
				coef_we   = 1'b1;
				fld_waddr = clr_q;
				fld_wdata = '0;
				aux_wdata = '0;
				b_wdata   = fdtd_pkg::UNITY;
				c_wdata   = '0;
				s_wdata   = fdtd_pkg::UNITY;
			end
			fdtd_pkg::ST_LOAD: begin
				coef_we   = in_range;
			end
			fdtd_pkg::ST_READ_ADDR: fld_raddr = IW'(idx_q);
			fdtd_pkg::ST_RD_LO:     fld_raddr = cur_q - IW'(1);
			fdtd_pkg::ST_RD_HI: begin
				fld_raddr  = cur_q + IW'(1);
				ctl.cap_lo = 1'b1;
			end
			fdtd_pkg::ST_RD_MID:    ctl.calc_diff = 1'b1;
			fdtd_pkg::ST_MUL1:      ctl.mul1 = 1'b1;
			fdtd_pkg::ST_SUM:       ctl.sum = 1'b1;
			fdtd_pkg::ST_MUL2: begin
				ctl.mul2 = 1'b1;
				aux_we   = 1'b1;
			end
			fdtd_pkg::ST_WB: begin
				ctl.wb = 1'b1;
				fld_we = 1'b1;
			end
			fdtd_pkg::ST_SRC_MUL:   ctl.src_mul = 1'b1;
			fdtd_pkg::ST_SRC_WB: begin
				ctl.src_wb = 1'b1;
				fld_we     = 1'b1;
				fld_waddr  = '0;
				fld_wdata  = src_field;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdtd_pkg::ST_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			odd_q       <= 1'b0;
			sat_q       <= 1'b0;
			rsat_q      <= 1'b0;
			step_q      <= '0;
			h_coef_q    <= '0;
			e_coef_q    <= '0;
			gain_q      <= fdtd_pkg::UNITY;
			al_q        <= {fdtd_pkg::CELL_W{1'b1}};
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fdtd_pkg::ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (cfg.valid) begin
				unique case (fdtd_pkg::cfg_index_t'(cfg.index))
					fdtd_pkg::CFG_H_COEF:        h_coef_q <= cfg.data;
					fdtd_pkg::CFG_E_COEF:        e_coef_q <= cfg.data;
					fdtd_pkg::CFG_SOURCE_GAIN:   gain_q   <= cfg.data;
					fdtd_pkg::CFG_ACTIVE_LENGTH: al_q     <= cfg.data[fdtd_pkg::CELL_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				rsat_q <= 1'b0;
				sat_q  <= 1'b0;
				cur_q  <= IW'(1);
				odd_q  <= 1'b1;
			end else begin
				sat_q <= sat_q | ovf;
			end
			if (state_q == fdtd_pkg::ST_WB) begin
				if (more) begin
					cur_q <= nxt[IW-1:0];
				end else if (more_even) begin
					cur_q <= IW'(2);
					odd_q <= 1'b0;
				end
			end
			if (state_q == fdtd_pkg::ST_SRC_WB) begin
				step_q <= step_q + DW'(1);
				rsat_q <= sat_q | ovf;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			idx_q <= item.cell_index;
			b_q   <= item.decay_value;
			c_q   <= item.couple_value;
			s_q   <= item.stretch_value;
			src_q <= item.source_value;
			rfv_q <= '0;
		end
		if (state_q == fdtd_pkg::ST_READ_DATA) rfv_q <= in_range ? fld_rd : '0;
		if (done_fire) begin
			out_fv_q   <= rfv_q;
			out_step_q <= step_q;
			out_sat_q  <= rsat_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.field_value = out_fv_q;
	assign result.step_number = out_step_q;
	assign result.saturated   = out_sat_q;

	fdtd_ram #(.WIDTH(DW), .DEPTH(fdtd_pkg::GRID_CELLS)) u_field (
		.clk, .we(fld_we), .waddr(fld_waddr), .wdata(fld_wdata),
		.raddr(fld_raddr), .rdata(fld_rd));
	fdtd_ram #(.WIDTH(DW), .DEPTH(fdtd_pkg::GRID_CELLS)) u_aux (
		.clk, .we(aux_we), .waddr(fld_waddr), .wdata(aux_wdata),
		.raddr(cur_q), .rdata(aux_rd));
	fdtd_ram #(.WIDTH(DW), .DEPTH(fdtd_pkg::GRID_CELLS)) u_decay (
		.clk, .we(coef_we), .waddr(state_q == fdtd_pkg::ST_CLEAR ? clr_q : IW'(idx_q)),
		.wdata(b_wdata), .raddr(cur_q), .rdata(b_rd));
	fdtd_ram #(.WIDTH(DW), .DEPTH(fdtd_pkg::GRID_CELLS)) u_couple (
		.clk, .we(coef_we), .waddr(state_q == fdtd_pkg::ST_CLEAR ? clr_q : IW'(idx_q)),
		.wdata(c_wdata), .raddr(cur_q), .rdata(c_rd));
	fdtd_ram #(.WIDTH(DW), .DEPTH(fdtd_pkg::GRID_CELLS)) u_stretch (
		.clk, .we(coef_we), .waddr(state_q == fdtd_pkg::ST_CLEAR ? clr_q : IW'(idx_q)),
		.wdata(s_wdata), .raddr(cur_q), .rdata(s_rd));

	fdtd_alu u_alu (
		.clk,
		.ctl,
		.field_rd  (fld_rd),
		.aux_rd    (aux_rd),
		.decay_rd  (b_rd),
		.couple_rd (c_rd),
		.stretch_rd(s_rd),
		.coef      (odd_q ? h_coef_q : e_coef_q),
		.source    (src_q),
		.gain      (gain_q),
		.aux_new,
		.field_new,
		.src_field,
		.ovf
	);

`ifndef NO_ASSERTIONS
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdtd_pkg::ST_CLEAR) |-> !result.valid)
		else $error("result during clearing pass");
	a_wb_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdtd_pkg::ST_WB) |-> (cur_q != '0) && (cur_q < last))
		else $error("cell write outside updated range");
	a_step_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fdtd_pkg::ST_SRC_WB) |=> (step_q == $past(step_q) + DW'(1)))
		else $error("step count not advanced by one");
`endif
endmodule

// ----- hdl/fdtd_ram.sv -----
module fdtd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/fdtd_alu.sv -----
module fdtd_alu (
	input  logic                               clk,
	input  fdtd_pkg::alu_ctl_t                 ctl,
	input  logic signed [fdtd_pkg::DATA_W-1:0] field_rd,
	input  logic signed [fdtd_pkg::DATA_W-1:0] aux_rd,
	input  logic signed [fdtd_pkg::DATA_W-1:0] decay_rd,
	input  logic signed [fdtd_pkg::DATA_W-1:0] couple_rd,
	input  logic signed [fdtd_pkg::DATA_W-1:0] stretch_rd,
	input  logic signed [fdtd_pkg::DATA_W-1:0] coef,
	input  logic signed [fdtd_pkg::DATA_W-1:0] source,
	input  logic signed [fdtd_pkg::DATA_W-1:0] gain,
	output logic signed [fdtd_pkg::DATA_W-1:0] aux_new,
	output logic signed [fdtd_pkg::DATA_W-1:0] field_new,
	output logic signed [fdtd_pkg::DATA_W-1:0] src_field,
	output logic                               ovf
);
	logic signed [fdtd_pkg::DATA_W-1:0] lo_s1, diff_s2, mid_s3, aux_s4, t_s4;
	logic signed [fdtd_pkg::ACC_W-1:0]  pb_s3, pc_s3, ps_s3, pt_s5, psrc_q;
	fdtd_pkg::clamp_t diff_c, aux_c, t_c, fld_c, src_c;

	always_comb begin
		diff_c = fdtd_pkg::clamp(fdtd_pkg::ACC_W'(field_rd) - fdtd_pkg::ACC_W'(lo_s1));
		aux_c  = fdtd_pkg::clamp(fdtd_pkg::fl(pb_s3) + fdtd_pkg::fl(pc_s3));
		t_c    = fdtd_pkg::clamp(fdtd_pkg::fl(ps_s3) + fdtd_pkg::ACC_W'(aux_c.val));
		fld_c  = fdtd_pkg::clamp(fdtd_pkg::ACC_W'(mid_s3) - fdtd_pkg::fl(pt_s5));
		src_c  = fdtd_pkg::clamp(fdtd_pkg::fl(psrc_q));
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_lo) begin
			lo_s1 <= field_rd;
		end
		if (ctl.calc_diff) begin
			diff_s2 <= diff_c.val;
		end
		if (ctl.mul1) begin
			mid_s3 <= field_rd;
			pb_s3  <= fdtd_pkg::ACC_W'(decay_rd) * fdtd_pkg::ACC_W'(aux_rd);
			pc_s3  <= fdtd_pkg::ACC_W'(couple_rd) * fdtd_pkg::ACC_W'(diff_s2);
			ps_s3  <= fdtd_pkg::ACC_W'(diff_s2) * fdtd_pkg::ACC_W'(stretch_rd);
		end
		if (ctl.sum) begin
			aux_s4 <= aux_c.val;
			t_s4   <= t_c.val;
		end
		if (ctl.mul2) begin
			pt_s5 <= fdtd_pkg::ACC_W'(t_s4) * fdtd_pkg::ACC_W'(coef);
		end
		if (ctl.src_mul) begin
			psrc_q <= fdtd_pkg::ACC_W'(source) * fdtd_pkg::ACC_W'(gain);
		end
	end

	assign aux_new   = aux_s4;
	assign field_new = fld_c.val;
	assign src_field = src_c.val;
	assign ovf = (ctl.calc_diff & diff_c.ovf) | (ctl.sum & (aux_c.ovf | t_c.ovf))
		| (ctl.wb & fld_c.ovf) | (ctl.src_wb & src_c.ovf);
endmodule
